>>> sv/msbbp_pkg.sv
// Shared types, constants and bit helpers of the MSB-first bit packer.
`timescale 1ns / 1ps
`default_nettype none

package msbbp_pkg;

  localparam int unsigned WORD_BITS    = 32;
  localparam int unsigned CAP_W        = 21;
  localparam int unsigned CNT_W        = 6;
  localparam int unsigned FILL_W       = 5;
  localparam int unsigned IDX_W        = 15;
  localparam int unsigned MAX_WORDS_DEF = 32768;
  localparam int unsigned OUT_DEPTH    = 8;

  localparam logic [CAP_W-1:0]     CAP_RESET = 21'h100000;
  localparam logic [WORD_BITS-1:0] FULL_MASK = 32'hffff_ffff;
  localparam logic [3:0]           BYTE_BITS = 4'd8;

  localparam logic ACT_PUT   = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef logic [CAP_W-1:0] cap_t;

  typedef struct packed {
    logic                 action;
    logic [CNT_W-1:0]     bit_count;
    logic [WORD_BITS-1:0] value;
    logic                 pad_to_byte;
    logic [WORD_BITS-1:0] prior_word;
  } req_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [IDX_W-1:0]     word_index;
    logic                 is_merged;
    logic                 overflow;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] acc;
    logic [FILL_W-1:0]    fill;
    logic [CAP_W-1:0]     rem;
    logic [IDX_W-1:0]     idx;
  } state_t;

  function automatic logic [WORD_BITS-1:0] shl32(input logic [WORD_BITS-1:0] v,
                                                 input logic [CNT_W-1:0] n);
    logic [WORD_BITS-1:0] r;
    r = (n >= 6'd32) ? '0 : (v << n);
    return r;
  endfunction

  function automatic logic [WORD_BITS-1:0] shr32(input logic [WORD_BITS-1:0] v,
                                                 input logic [CNT_W-1:0] n);
    logic [WORD_BITS-1:0] r;
    r = (n >= 6'd32) ? '0 : (v >> n);
    return r;
  endfunction

  function automatic logic [WORD_BITS-1:0] low_mask(input logic [CNT_W-1:0] n);
    logic [WORD_BITS-1:0] r;
    r = (n >= 6'd32) ? FULL_MASK : ~(FULL_MASK << n);
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/msbbp_chan_if.sv
// Valid/ready channel carrying one payload type.
`timescale 1ns / 1ps
`default_nettype none

interface msbbp_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/msbbp_step.sv
// Combinational step: appends one request to the packer state and forms its results.
`timescale 1ns / 1ps
`default_nettype none

module msbbp_step #(
  parameter int unsigned MAX_WORDS = msbbp_pkg::MAX_WORDS_DEF
) (
  input  msbbp_pkg::req_t   req,
  input  msbbp_pkg::state_t cur,
  output msbbp_pkg::state_t nxt,
  output logic [1:0]        res_n,
  output msbbp_pkg::res_t   res0,
  output msbbp_pkg::res_t   res1
);

  logic        put_ovf;
  logic        pad_ovf;
  logic        ovf;
  logic [2:0]  part;
  logic [3:0]  padn;
  logic        do_pad;
  logic [5:0]  app_n;
  logic [31:0] app_v;
  logic [5:0]  sum;
  logic        done;
  logic [5:0]  nf;
  logic [5:0]  free_bits;
  logic [5:0]  free_after;
  logic [31:0] full_word;
  logic [31:0] merged;
  logic [20:0] idx_inc;
  logic [14:0] idx_adv;
  msbbp_pkg::state_t app;
  msbbp_pkg::res_t   ovf_res;
  msbbp_pkg::res_t   full_res;
  msbbp_pkg::res_t   mrg_res;

  always_comb begin
    put_ovf = (req.bit_count > 6'd32) || ({15'b0, req.bit_count} > cur.rem);
    part    = cur.fill[2:0];
    padn    = msbbp_pkg::BYTE_BITS - {1'b0, part};
    do_pad  = req.pad_to_byte && (part != 3'd0);
    pad_ovf = do_pad && ({17'b0, padn} > cur.rem);
    ovf     = (req.action == msbbp_pkg::ACT_FLUSH) ? pad_ovf : put_ovf;

    // a flush appends only its zero padding
    if (req.action == msbbp_pkg::ACT_FLUSH) begin
      app_n = do_pad ? {2'b0, padn} : 6'd0;
      app_v = '0;
    end else begin
      app_n = req.bit_count;
      app_v = req.value & msbbp_pkg::low_mask(req.bit_count);
    end

    sum       = {1'b0, cur.fill} + app_n;
    done      = sum[5];
    nf        = {1'b0, sum[4:0]};
    free_bits = 6'd32 - {1'b0, cur.fill};
    full_word = msbbp_pkg::shl32(cur.acc, free_bits) | msbbp_pkg::shr32(app_v, nf);

    idx_inc = {6'b0, cur.idx} + 21'd1;
    idx_adv = (idx_inc == 21'(MAX_WORDS)) ? '0 : idx_inc[14:0];

    app.acc  = done ? (app_v & msbbp_pkg::low_mask(nf))
                    : (msbbp_pkg::shl32(cur.acc, app_n) | app_v);
    app.fill = sum[4:0];
    app.rem  = cur.rem - {15'b0, app_n};
    app.idx  = done ? idx_adv : cur.idx;

    free_after = 6'd32 - {1'b0, app.fill};
    merged     = msbbp_pkg::shl32(app.acc, free_after)
               | (req.prior_word & msbbp_pkg::low_mask(free_after));

    ovf_res  = '{word: '0, word_index: '0, is_merged: 1'b0, overflow: 1'b1, last: 1'b1};
    full_res = '{word: full_word, word_index: cur.idx, is_merged: 1'b0, overflow: 1'b0,
                 last: (req.action == msbbp_pkg::ACT_PUT)};
    mrg_res  = '{word: merged, word_index: app.idx, is_merged: 1'b1, overflow: 1'b0,
                 last: 1'b1};

    nxt  = ovf ? cur : app;
    res1 = mrg_res;
    if (ovf) begin
      res_n = 2'd1;
      res0  = ovf_res;
    end else if (req.action == msbbp_pkg::ACT_PUT) begin
      res_n = done ? 2'd1 : 2'd0;
      res0  = full_res;
    end else begin
      res_n = done ? 2'd2 : 2'd1;
      res0  = done ? full_res : mrg_res;
    end
  end

endmodule

`default_nettype wire

>>> sv/msbbp_out_fifo.sv
// Result queue: takes up to two results a cycle, gives one a cycle while popped.
`timescale 1ns / 1ps
`default_nettype none

module msbbp_out_fifo #(
  parameter int unsigned DEPTH = msbbp_pkg::OUT_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [1:0]               push_n,
  input  msbbp_pkg::res_t          push0,
  input  msbbp_pkg::res_t          push1,
  input  logic                     pop,
  output msbbp_pkg::res_t          head,
  output logic                     not_empty,
  output logic [$clog2(DEPTH):0]   cnt
);

  localparam int unsigned PTR_W = $clog2(DEPTH);

  msbbp_pkg::res_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [PTR_W:0]   cnt_r, cnt_nxt;
  logic [PTR_W-1:0] wptr_p1;
  logic             do_pop;

  assign wptr_p1   = wptr_r + PTR_W'(1);
  assign not_empty = (cnt_r != '0);
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rptr_r];
  assign cnt       = cnt_r;

  always_comb begin
    wptr_nxt = wptr_r + PTR_W'(push_n);
    rptr_nxt = do_pop ? rptr_r + PTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r + (PTR_W+1)'(push_n) - (PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem_r[wptr_p1] <= push1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PTR_W+1)'(DEPTH))
    else $error("result queue count above depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cnt_r} + (PTR_W+2)'(push_n)) <= ((PTR_W+2)'(DEPTH) + (PTR_W+2)'(do_pop)))
    else $error("result queue overrun");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && push_n == 2'd0) |=> (cnt_r == $past(cnt_r) - (PTR_W+1)'(1)))
    else $error("result queue count did not drop on pop");

endmodule

`default_nettype wire

>>> sv/msb_first_bit_packer_unit.sv
// MSB-first bit packer: packs 0..32-bit fields into 32-bit big-endian words.
//
//   port    dir  carries
//   in_ch   in   request: action, bit_count, value, pad_to_byte, prior_word
//   out_ch  out  result: word, word_index, is_merged, overflow, last
//   cfg_ch  in   capacity_bits write (21 bits), restarts the stream
//
// One request per cycle while in_ch.ready is high: a request is registered,
// packed in one pass of shift/mask logic against the packer state, and its
// 0..2 results land in an 8-entry result queue that drains one result per
// cycle while out_ch.ready is high; results pass the request register, then the queue.
// in_ch.ready drops while the queue holds more than four results.
// Synchronous reset sets capacity to 1048576 bits and clears the stream.
`timescale 1ns / 1ps
`default_nettype none

module msb_first_bit_packer_unit #(
  parameter int unsigned MAX_WORDS = msbbp_pkg::MAX_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  msbbp_chan_if.sink         in_ch,
  msbbp_chan_if.source       out_ch,
  msbbp_chan_if.sink         cfg_ch
);

  localparam int unsigned DEPTH = msbbp_pkg::OUT_DEPTH;
  localparam int unsigned CNT_Q = $clog2(DEPTH) + 1;

  logic              s_v_r, s_v_nxt;
  msbbp_pkg::req_t   s_req_r;
  msbbp_pkg::state_t st_r, st_nxt;
  msbbp_pkg::cap_t   cap_r, cap_nxt;
  msbbp_pkg::state_t step_nxt;
  logic [1:0]        res_n;
  logic [1:0]        push_n;
  msbbp_pkg::res_t   res0;
  msbbp_pkg::res_t   res1;
  logic [CNT_Q-1:0]  q_cnt;
  logic              in_acc;
  logic              cfg_acc;

  assign in_ch.ready  = (q_cnt <= CNT_Q'(DEPTH - 4));
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_acc      = cfg_ch.valid;
  assign push_n       = s_v_r ? res_n : 2'd0;

  msbbp_step #(
    .MAX_WORDS (MAX_WORDS)
  ) u_step (
    .req   (s_req_r),
    .cur   (st_r),
    .nxt   (step_nxt),
    .res_n (res_n),
    .res0  (res0),
    .res1  (res1)
  );

  msbbp_out_fifo #(
    .DEPTH (DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push0     (res0),
    .push1     (res1),
    .pop       (out_ch.ready),
    .head      (out_ch.data),
    .not_empty (out_ch.valid),
    .cnt       (q_cnt)
  );

  always_comb begin
    s_v_nxt = in_acc;
    cap_nxt = cap_r;
    st_nxt  = st_r;
    if (cfg_acc) begin
      // restart the stream at the new capacity
      cap_nxt = cfg_ch.data;
      st_nxt  = '{acc: '0, fill: '0, rem: cfg_ch.data, idx: '0};
    end else if (s_v_r) begin
      st_nxt = step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
      cap_r <= msbbp_pkg::CAP_RESET;
      st_r  <= '{acc: '0, fill: '0, rem: msbbp_pkg::CAP_RESET, idx: '0};
    end else begin
      s_v_r <= s_v_nxt;
      cap_r <= cap_nxt;
      st_r  <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_req_r <= in_ch.data;
    end
  end

  a_rem_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.rem <= cap_r)
    else $error("remaining bits exceed capacity");

  a_ovf_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s_v_r && res_n != 2'd0 && res0.overflow && !cfg_acc) |=> $stable(st_r))
    else $error("overflowed request changed packer state");

  a_pad_aligns: assert property (@(posedge clk) disable iff (!rst_n)
    (s_v_r && s_req_r.action == msbbp_pkg::ACT_FLUSH && s_req_r.pad_to_byte
     && !res0.overflow && !cfg_acc) |=> (st_r.fill[2:0] == 3'd0))
    else $error("padded flush left a partial byte");

endmodule

`default_nettype wire
